// File: rtl/outline_to_type2_charstring_core_macros.svh
`ifndef OUTLINE_TO_TYPE2_CHARSTRING_CORE_MACROS_SVH
`define OUTLINE_TO_TYPE2_CHARSTRING_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OTC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define OTC_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define OTC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define OTC_ASSERT_NEXT(lbl, clk, rst, a, c, msg)
`endif

`endif

// File: rtl/otc_pkg.sv
package otc_pkg;

   localparam int MaxResults = 42;
   localparam int CountW     = $clog2(MaxResults + 1);

   localparam logic [7:0] CMD_VMOVE   = 8'd4;
   localparam logic [7:0] CMD_RLINE   = 8'd5;
   localparam logic [7:0] CMD_RCURVE  = 8'd8;
   localparam logic [7:0] CMD_GLYPH_END = 8'd14;
   localparam logic [7:0] CMD_RMOVE   = 8'd21;
   localparam logic [7:0] CMD_HMOVE   = 8'd22;
   localparam logic [7:0] PFX_SHORT   = 8'd28;
   localparam logic [7:0] PFX_LONG    = 8'd29;
   localparam logic [7:0] PFX_FIXED   = 8'd255;
   localparam logic [7:0] BIAS_SMALL  = 8'd139;
   localparam logic [7:0] BASE_POS    = 8'd247;
   localparam logic [7:0] BASE_NEG    = 8'd251;

   localparam logic [1:0] ACT_BEGIN = 2'd0;
   localparam logic [1:0] ACT_POINT = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic [0:0] CSR_DEFAULT_WIDTH = 1'b0;
   localparam logic [0:0] CSR_NOMINAL_WIDTH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_HANDLE, ST_CLOSE, ST_CLOSE_LINE, ST_EMIT, ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      MK_MOVE, MK_LINE, MK_CURVE, MK_WIDTH, MK_END
   } macro_type;

   typedef enum logic [1:0] {
      MF_V, MF_H, MF_R
   } form_type;

   typedef enum logic [3:0] {
      N_TX_CUR, N_TY_CUR, N_C0X_CUR, N_C0Y_CUR, N_C1X_C0X, N_C1Y_C0Y,
      N_TX_C1X, N_TY_C1Y, N_WIDTH
   } num_sel_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [0:4][7:0] bytes;
   } enc_type;

   typedef struct packed {
      logic        begin_clear;
      logic        set_start;
      logic        store_c0;
      logic        store_c1;
      logic        commit;
      logic        tgt_start;
      logic        load;
      logic        load_op;
      num_sel_type num_sel;
      logic [7:0]  op_byte;
      logic        flush;
   } cmd_type;

   typedef struct packed {
      logic       ser_empty;
      logic       sink_ready;
      logic [1:0] action;
      logic       on_curve;
      logic       contour_last;
      logic       width_ne;
      logic       eq_x;
      logic       eq_y;
   } sts_type;

   function automatic enc_type enc_int(input logic signed [31:0] v);
      enc_type     e;
      logic [31:0] w;
      begin
         e.len   = 3'd1;
         e.bytes = '0;
         w       = '0;
         if (v >= -107 && v <= 107) begin
            w = 32'(v + 139);
            e.bytes[0] = w[7:0];
         end else if (v >= 108 && v <= 1131) begin
            w = 32'(v - 108);
            e.len = 3'd2;
            e.bytes[0] = 8'(w[15:8] + BASE_POS);
            e.bytes[1] = w[7:0];
         end else if (v >= -1131 && v <= -108) begin
            w = 32'(-v - 108);
            e.len = 3'd2;
            e.bytes[0] = 8'(w[15:8] + BASE_NEG);
            e.bytes[1] = w[7:0];
         end else if (v >= -32768 && v <= 32767) begin
            e.len = 3'd3;
            e.bytes[0] = PFX_SHORT;
            e.bytes[1] = v[15:8];
            e.bytes[2] = v[7:0];
         end else begin
            e.len = 3'd5;
            e.bytes[0] = PFX_LONG;
            e.bytes[1] = v[31:24];
            e.bytes[2] = v[23:16];
            e.bytes[3] = v[15:8];
            e.bytes[4] = v[7:0];
         end
         return e;
      end
   endfunction

   function automatic enc_type enc_num(input logic [31:0] d);
      enc_type e;
      begin
         if (d[15:0] == 16'd0) begin
            e = enc_int({{16{d[31]}}, d[31:16]});
         end else begin
            e.len = 3'd5;
            e.bytes[0] = PFX_FIXED;
            e.bytes[1] = d[31:24];
            e.bytes[2] = d[23:16];
            e.bytes[3] = d[15:8];
            e.bytes[4] = d[7:0];
         end
         return e;
      end
   endfunction

endpackage

// File: rtl/otc_datapath.sv
module otc_datapath
   import otc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              latch,
   input  logic [1:0]        req_action,
   input  logic signed [30:0] req_pos_x,
   input  logic signed [30:0] req_pos_y,
   input  logic              req_on_curve,
   input  logic              req_contour_last,
   input  logic signed [15:0] req_advance,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last
);

   logic [15:0] dflt_ff, nom_ff;
   logic [1:0]  act_ff;
   logic [31:0] px_ff, py_ff, cur_x_ff, cur_y_ff, st_x_ff, st_y_ff;
   logic [31:0] c0x_ff, c0y_ff, c1x_ff, c1y_ff;
   logic        on_ff, last_ff;
   logic [15:0] adv_ff;
   logic [0:4][7:0] sh_ff;
   logic [2:0]  cnt_ff;
   logic [CountW-1:0] ecount_ff;
   logic [7:0]  hold_ff, out_ff;
   logic        hold_v_ff, valid_ff, last_out_ff;

   logic [31:0] tx, ty, op_a, op_b, diff;
   logic signed [31:0] wv;
   enc_type     enc;
   logic        sink_ready, emit_fire, emit_keep, flush_go;

   assign sink_ready = !valid_ff || !rsp_stall;
   assign emit_fire  = (cnt_ff != 3'd0) && sink_ready && !cmd.load;
   assign emit_keep  = emit_fire && (ecount_ff < CountW'(MaxResults));
   assign flush_go   = cmd.flush && hold_v_ff && sink_ready;

   assign tx = cmd.tgt_start ? st_x_ff : px_ff;
   assign ty = cmd.tgt_start ? st_y_ff : py_ff;
   assign wv = {{16{adv_ff[15]}}, adv_ff} - {{16{nom_ff[15]}}, nom_ff};

   always_comb begin
      op_a = tx;
      op_b = cur_x_ff;
      case (cmd.num_sel)
         N_TX_CUR:  begin op_a = tx;     op_b = cur_x_ff; end
         N_TY_CUR:  begin op_a = ty;     op_b = cur_y_ff; end
         N_C0X_CUR: begin op_a = c0x_ff; op_b = cur_x_ff; end
         N_C0Y_CUR: begin op_a = c0y_ff; op_b = cur_y_ff; end
         N_C1X_C0X: begin op_a = c1x_ff; op_b = c0x_ff;   end
         N_C1Y_C0Y: begin op_a = c1y_ff; op_b = c0y_ff;   end
         N_TX_C1X:  begin op_a = tx;     op_b = c1x_ff;   end
         N_TY_C1Y:  begin op_a = ty;     op_b = c1y_ff;   end
         default:   begin op_a = tx;     op_b = cur_x_ff; end
      endcase
      diff = op_a - op_b;
      if (cmd.load_op) begin
         enc.len   = 3'd1;
         enc.bytes = '0;
         enc.bytes[0] = cmd.op_byte;
      end else if (cmd.num_sel == N_WIDTH) begin
         enc = enc_int(wv);
      end else begin
         enc = enc_num(diff);
      end
   end

   assign sts.ser_empty    = (cnt_ff == 3'd0);
   assign sts.sink_ready   = sink_ready;
   assign sts.action       = act_ff;
   assign sts.on_curve     = on_ff;
   assign sts.contour_last = last_ff;
   assign sts.width_ne     = (adv_ff != dflt_ff);
   assign sts.eq_x         = (st_x_ff == cur_x_ff);
   assign sts.eq_y         = (st_y_ff == cur_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= '0;
         nom_ff  <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         st_x_ff <= '0;
         st_y_ff <= '0;
         c0x_ff <= '0;
         c0y_ff <= '0;
         c1x_ff <= '0;
         c1y_ff <= '0;
         act_ff <= ACT_BEGIN;
         cnt_ff <= '0;
         ecount_ff <= '0;
         hold_v_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEFAULT_WIDTH: dflt_ff <= csr_data;
               CSR_NOMINAL_WIDTH: nom_ff  <= csr_data;
               default: ;
            endcase
         end
         if (latch) begin
            act_ff <= req_action;
            ecount_ff <= '0;
         end
         if (cmd.begin_clear) begin
            cur_x_ff <= '0;
            cur_y_ff <= '0;
            st_x_ff <= '0;
            st_y_ff <= '0;
         end
         if (cmd.set_start) begin
            st_x_ff <= px_ff;
            st_y_ff <= py_ff;
         end
         if (cmd.store_c0) begin
            c0x_ff <= px_ff;
            c0y_ff <= py_ff;
         end
         if (cmd.store_c1) begin
            c1x_ff <= px_ff;
            c1y_ff <= py_ff;
         end
         if (cmd.commit) begin
            cur_x_ff <= tx;
            cur_y_ff <= ty;
         end
         if ((emit_keep && hold_v_ff) || flush_go) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (cmd.load) begin
            cnt_ff <= enc.len;
         end else if (emit_fire) begin
            cnt_ff <= cnt_ff - 3'd1;
         end
         if (emit_keep) begin
            ecount_ff <= ecount_ff + CountW'(1);
            hold_v_ff <= 1'b1;
         end
         if (flush_go) begin
            hold_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (latch) begin
         px_ff   <= {req_pos_x[30], req_pos_x};
         py_ff   <= {req_pos_y[30], req_pos_y};
         on_ff   <= req_on_curve;
         last_ff <= req_contour_last;
         adv_ff  <= req_advance;
      end
      if (cmd.load) begin
         sh_ff <= enc.bytes;
      end else if (emit_fire) begin
         sh_ff <= {sh_ff[1:4], 8'h00};
      end
      if (emit_keep) begin
         hold_ff <= sh_ff[0];
         if (hold_v_ff) begin
            out_ff <= hold_ff;
            last_out_ff <= 1'b0;
         end
      end
      if (flush_go) begin
         out_ff <= hold_ff;
         last_out_ff <= 1'b1;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = out_ff;
   assign rsp_run_last = last_out_ff;

endmodule

// File: rtl/otc_control.sv
module otc_control
   import otc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    latch,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   state_type state_ff, state_in, ret_ff, ret_in;
   macro_type kind_ff, kind_in;
   form_type  form_ff, form_in;
   logic [2:0] step_ff, step_in, nsteps;
   logic       tgt_ff, tgt_in;
   logic [1:0] ps_ff, ps_in, pend_ff, pend_in;
   logic       macro_done;

   always_comb begin
      case (kind_ff)
         MK_MOVE:  nsteps = (form_ff == MF_R) ? 3'd3 : 3'd2;
         MK_LINE:  nsteps = 3'd3;
         MK_CURVE: nsteps = 3'd7;
         default:  nsteps = 3'd1;
      endcase
   end

   assign macro_done = sts.ser_empty && (step_ff == nsteps);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (latch) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (sts.action)
               ACT_BEGIN: state_in = sts.width_ne ? ST_EMIT : ST_FLUSH;
               ACT_POINT: begin
                  if (ps_ff == 2'd0) state_in = ST_CLOSE;
                  else if (ps_ff == 2'd1) state_in = ST_EMIT;
                  else state_in = ST_HANDLE;
               end
               ACT_END:   state_in = ST_EMIT;
               default:   state_in = ST_FLUSH;
            endcase
         end
         ST_HANDLE: begin
            if ((pend_ff == 2'd0 && sts.on_curve) || pend_ff == 2'd2) state_in = ST_EMIT;
            else state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (!sts.contour_last || ps_ff != 2'd2) state_in = ST_FLUSH;
            else if (pend_ff == 2'd2) state_in = ST_EMIT;
            else state_in = ST_CLOSE_LINE;
         end
         ST_CLOSE_LINE: state_in = (sts.eq_x && sts.eq_y) ? ST_FLUSH : ST_EMIT;
         ST_EMIT:  if (macro_done) state_in = ret_ff;
         ST_FLUSH: if (sts.ser_empty && sts.sink_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.num_sel = N_TX_CUR;
      cmd.tgt_start = tgt_ff;
      kind_in = kind_ff;
      form_in = form_ff;
      step_in = step_ff;
      tgt_in  = tgt_ff;
      ret_in  = ret_ff;
      ps_in   = ps_ff;
      pend_in = pend_ff;
      unique case (state_ff)
         ST_IDLE: ;
         ST_DISPATCH: begin
            step_in = 3'd0;
            ret_in  = ST_FLUSH;
            unique case (sts.action)
               ACT_BEGIN: begin
                  cmd.begin_clear = 1'b1;
                  ps_in = 2'd0;
                  pend_in = 2'd0;
                  kind_in = MK_WIDTH;
               end
               ACT_POINT: begin
                  if (ps_ff == 2'd0) begin
                     cmd.set_start = 1'b1;
                     ps_in = 2'd1;
                     pend_in = 2'd0;
                  end else if (ps_ff == 2'd1) begin
                     ps_in = 2'd2;
                     kind_in = MK_MOVE;
                     tgt_in = 1'b1;
                     ret_in = ST_HANDLE;
                     if (sts.eq_x && !sts.eq_y) form_in = MF_V;
                     else if (sts.eq_y && !sts.eq_x) form_in = MF_H;
                     else form_in = MF_R;
                  end
               end
               ACT_END: begin
                  ps_in = 2'd0;
                  pend_in = 2'd0;
                  kind_in = MK_END;
               end
               default: ;
            endcase
         end
         ST_HANDLE: begin
            step_in = 3'd0;
            tgt_in  = 1'b0;
            ret_in  = ST_CLOSE;
            if (pend_ff == 2'd0) begin
               if (sts.on_curve) kind_in = MK_LINE;
               else begin
                  cmd.store_c0 = 1'b1;
                  pend_in = 2'd1;
               end
            end else if (pend_ff == 2'd1) begin
               cmd.store_c1 = 1'b1;
               pend_in = 2'd2;
            end else begin
               kind_in = MK_CURVE;
               pend_in = 2'd0;
            end
         end
         ST_CLOSE: begin
            step_in = 3'd0;
            tgt_in  = 1'b1;
            kind_in = MK_CURVE;
            ret_in  = ST_CLOSE_LINE;
            if (sts.contour_last) begin
               ps_in = 2'd0;
               pend_in = 2'd0;
            end
         end
         ST_CLOSE_LINE: begin
            step_in = 3'd0;
            tgt_in  = 1'b1;
            kind_in = MK_LINE;
            ret_in  = ST_FLUSH;
         end
         ST_EMIT: begin
            if (sts.ser_empty) begin
               if (step_ff == nsteps) begin
                  cmd.commit = (kind_ff == MK_MOVE) || (kind_ff == MK_LINE)
                     || (kind_ff == MK_CURVE);
               end else begin
                  cmd.load = 1'b1;
                  step_in = step_ff + 3'd1;
                  case (kind_ff)
                     MK_MOVE: begin
                        if (step_ff == nsteps - 3'd1) begin
                           cmd.load_op = 1'b1;
                           case (form_ff)
                              MF_V:    cmd.op_byte = CMD_VMOVE;
                              MF_H:    cmd.op_byte = CMD_HMOVE;
                              default: cmd.op_byte = CMD_RMOVE;
                           endcase
                        end else if (form_ff == MF_V || step_ff == 3'd1) begin
                           cmd.num_sel = N_TY_CUR;
                        end else begin
                           cmd.num_sel = N_TX_CUR;
                        end
                     end
                     MK_LINE: begin
                        case (step_ff)
                           3'd0:    cmd.num_sel = N_TX_CUR;
                           3'd1:    cmd.num_sel = N_TY_CUR;
                           default: begin
                              cmd.load_op = 1'b1;
                              cmd.op_byte = CMD_RLINE;
                           end
                        endcase
                     end
                     MK_CURVE: begin
                        case (step_ff)
                           3'd0:    cmd.num_sel = N_C0X_CUR;
                           3'd1:    cmd.num_sel = N_C0Y_CUR;
                           3'd2:    cmd.num_sel = N_C1X_C0X;
                           3'd3:    cmd.num_sel = N_C1Y_C0Y;
                           3'd4:    cmd.num_sel = N_TX_C1X;
                           3'd5:    cmd.num_sel = N_TY_C1Y;
                           default: begin
                              cmd.load_op = 1'b1;
                              cmd.op_byte = CMD_RCURVE;
                           end
                        endcase
                     end
                     MK_WIDTH: cmd.num_sel = N_WIDTH;
                     default: begin
                        cmd.load_op = 1'b1;
                        cmd.op_byte = CMD_GLYPH_END;
                     end
                  endcase
               end
            end
         end
         ST_FLUSH: cmd.flush = sts.ser_empty && sts.sink_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         kind_ff  <= MK_END;
         form_ff  <= MF_R;
         step_ff  <= '0;
         tgt_ff   <= 1'b0;
         ps_ff    <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         kind_ff  <= kind_in;
         form_ff  <= form_in;
         step_ff  <= step_in;
         tgt_ff   <= tgt_in;
         ps_ff    <= ps_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// File: rtl/outline_to_type2_charstring_core.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  action, pos_x, pos_y, on_curve, contour_last, advance
// rsp_      out        rsp_valid/rsp_stall  out_byte, run_last
// csr_      in         csr_valid/csr_ready  index, data (16 bit)
// one request runs through the sequencing states, then, for every number or operator it writes,
// one load into the serializer and one byte per cycle while rsp_stall is low (up to 42 bytes)
// req_stall stays high until the last byte has entered the output register
// synchronous active-high reset clears the pen, start and control points and both width registers
// rsp_stall holds the serializer; csr writes are always ready
`include "outline_to_type2_charstring_core_macros.svh"
module outline_to_type2_charstring_core
   import otc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [30:0] req_pos_x,
   input  logic signed [30:0] req_pos_y,
   input  logic               req_on_curve,
   input  logic               req_contour_last,
   input  logic signed [15:0] req_advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;
   logic    busy, latch, csr_we;

   assign req_stall = busy;
   assign latch     = req_valid && !busy;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && (csr_index[1] == 1'b0);

   otc_control u_control (
      .clock (clock),
      .reset (reset),
      .latch (latch),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   otc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .latch            (latch),
      .req_action       (req_action),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_on_curve     (req_on_curve),
      .req_contour_last (req_contour_last),
      .req_advance      (req_advance),
      .csr_we           (csr_we),
      .csr_index        (csr_index[0]),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last)
   );

   `OTC_ASSERT_NEXT(a_busy_after_req, clock, reset, latch, req_stall, "no busy after request")
   `OTC_ASSERT_NEVER(a_load_busy, clock, reset, cmd.load && !sts.ser_empty, "load into busy serializer")
   `OTC_ASSERT_NEVER(a_flush_busy, clock, reset, cmd.flush && !sts.ser_empty, "flush with bytes left")

endmodule

// File: tb/tb_outline_to_type2_charstring_core.sv
module tb_outline_to_type2_charstring_core;
   import otc_pkg::*;

   class charstring_board;
      logic [7:0] bytes_q[$];
      logic       last_q[$];
      int         errors = 0;
      int         checked = 0;
      logic signed [15:0] dflt_w = 0, nom_w = 0;
      logic [31:0] cur_x = 0, cur_y = 0, start_x = 0, start_y = 0;
      logic [31:0] ctl_x[2], ctl_y[2];
      int          pend = 0, seen = 0;
      logic [7:0]  run[$];

      function void put(logic [7:0] b);
         run.insert(run.size(), b);
      endfunction

      function void put32(logic [31:0] u);
         put(u[31:24]); put(u[23:16]); put(u[15:8]); put(u[7:0]);
      endfunction

      function void put_int(int v);
         logic [31:0] w;
         w = v;
         if (v >= -107 && v <= 107) put(8'(v + 139));
         else if (v >= 108 && v <= 1131) begin
            w = v - 108; put(8'(w[15:8] + 247)); put(w[7:0]);
         end else if (v >= -1131 && v <= -108) begin
            w = -v - 108; put(8'(w[15:8] + 251)); put(w[7:0]);
         end else if (v >= -32768 && v <= 32767) begin
            put(PFX_SHORT); put(w[15:8]); put(w[7:0]);
         end else begin
            put(PFX_LONG); put32(w);
         end
      endfunction

      function void put_num(logic [31:0] d);
         if (d[15:0] == 0) put_int(int'($signed(d[31:16])));
         else begin
            put(PFX_FIXED); put32(d);
         end
      endfunction

      function void move_to(logic [31:0] x, logic [31:0] y);
         logic [31:0] dx, dy;
         dx = x - cur_x; dy = y - cur_y;
         if (dx == 0 && dy != 0) begin
            put_num(dy); put(CMD_VMOVE);
         end else if (dy == 0 && dx != 0) begin
            put_num(dx); put(CMD_HMOVE);
         end else begin
            put_num(dx); put_num(dy); put(CMD_RMOVE);
         end
         cur_x = x; cur_y = y;
      endfunction

      function void line_to(logic [31:0] x, logic [31:0] y);
         put_num(x - cur_x); put_num(y - cur_y); put(CMD_RLINE);
         cur_x = x; cur_y = y;
      endfunction

      function void curve_to(logic [31:0] x, logic [31:0] y);
         put_num(ctl_x[0] - cur_x); put_num(ctl_y[0] - cur_y);
         put_num(ctl_x[1] - ctl_x[0]); put_num(ctl_y[1] - ctl_y[0]);
         put_num(x - ctl_x[1]); put_num(y - ctl_y[1]);
         put(CMD_RCURVE);
         cur_x = x; cur_y = y;
      endfunction

      function void note_request(logic [1:0] act, logic signed [30:0] px,
                                 logic signed [30:0] py, logic on, logic last,
                                 logic signed [15:0] adv);
         logic [31:0] x, y;
         x = 32'(px); y = 32'(py);
         run.delete();
         if (act == ACT_BEGIN) begin
            cur_x = 0; cur_y = 0; start_x = 0; start_y = 0; pend = 0; seen = 0;
            if (adv != dflt_w) put_int(int'(adv) - int'(nom_w));
         end else if (act == ACT_POINT) begin
            if (seen == 0) begin
               start_x = x; start_y = y; pend = 0; seen = 1;
            end else begin
               if (seen == 1) begin
                  move_to(start_x, start_y); seen = 2;
               end
               if (pend == 0) begin
                  if (on) line_to(x, y);
                  else begin
                     ctl_x[0] = x; ctl_y[0] = y; pend = 1;
                  end
               end else if (pend == 1) begin
                  ctl_x[1] = x; ctl_y[1] = y; pend = 2;
               end else begin
                  curve_to(x, y); pend = 0;
               end
            end
            if (last) begin
               if (seen == 2) begin
                  if (pend == 2) curve_to(start_x, start_y);
                  if (cur_x != start_x || cur_y != start_y) line_to(start_x, start_y);
               end
               pend = 0; seen = 0;
            end
         end else if (act == ACT_END) begin
            pend = 0; seen = 0; put(CMD_GLYPH_END);
         end
         foreach (run[i]) begin
            bytes_q.insert(bytes_q.size(), run[i]);
            last_q.insert(last_q.size(), i == run.size() - 1);
         end
      endfunction

      function void check_byte(logic [7:0] b, logic l);
         logic [7:0] eb;
         logic el;
         checked++;
         if (bytes_q.size() == 0) begin
            $display("%0t unexpected byte: expected none, actual %0d/%0d", $time, b, l);
            errors++;
            return;
         end
         eb = bytes_q.pop_front(); el = last_q.pop_front();
         if (eb !== b) begin
            $display("%0t out_byte: expected %0d, actual %0d", $time, eb, b); errors++;
         end
         if (el !== l) begin
            $display("%0t run_last: expected %0d, actual %0d", $time, el, l); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_action = 0;
   logic signed [30:0] req_pos_x = 0, req_pos_y = 0;
   logic req_on_curve = 0, req_contour_last = 0;
   logic signed [15:0] req_advance = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = 0;
   logic [15:0] csr_data = 0;

   charstring_board board = new();
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   int  sent = 0;

   outline_to_type2_charstring_core dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_byte(rsp_out_byte, rsp_run_last);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb_outline_to_type2_charstring_core: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      int w;
      if (reset || hold_rsp) rsp_stall <= 1;
      else if ($urandom_range(0, 3) == 0) begin
         w = $urandom_range(0, 5);
         if (w != 0) begin
            rsp_stall <= 1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 0;
      end else rsp_stall <= 0;
   end

   task automatic send(logic [1:0] act, logic signed [30:0] x, logic signed [30:0] y,
                       logic on, logic last, logic signed [15:0] adv, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_action <= act; req_pos_x <= x; req_pos_y <= y;
      req_on_curve <= on; req_contour_last <= last; req_advance <= adv;
      do @(posedge clock); while (req_stall);
      board.note_request(act, x, y, on, last, adv);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.bytes_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx[0] == CSR_DEFAULT_WIDTH) board.dflt_w = val; else board.nom_w = val;
      @(posedge clock);
   endtask

   function automatic logic signed [30:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 31'($signed($urandom_range(0, 200)) - 100) <<< 16;
         1: return 31'($signed($urandom_range(0, 4000)) - 2000) <<< 16;
         2: return 31'($urandom);
         3: return $urandom_range(0, 1) ? 31'sh3FFF_FFFF : -31'sh4000_0000;
         default: return 31'($signed($urandom_range(0, 80000)) - 40000) <<< 16;
      endcase
   endfunction

   task automatic random_glyph(int gaps);
      int nc, np;
      send(ACT_BEGIN, 0, 0, 0, 0, 16'($urandom), gaps ? $urandom_range(0, 5) : 0);
      nc = $urandom_range(1, 3);
      repeat (nc) begin
         np = $urandom_range(1, 8);
         for (int i = 0; i < np; i++)
            send(ACT_POINT, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                 (i == np - 1) || ($urandom_range(0, 15) == 0), 16'($urandom),
                 gaps ? $urandom_range(0, 5) : 0);
      end
      send($urandom_range(0, 5) == 0 ? ACT_SPARE : ACT_END, rand_coord(), rand_coord(),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom),
           gaps ? $urandom_range(0, 5) : 0);
   endtask

   initial begin
      logic [15:0] dw[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd500};
      logic [15:0] nw[4] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFF00};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(ACT_POINT, 31'sh10000, 0, 1, 0, 0, 0);
      send(ACT_POINT, 31'sh20000, 0, 1, 1, 0, 0);
      send(ACT_BEGIN, 0, 0, 0, 0, 16'sh7FFF, 0);
      send(ACT_BEGIN, 0, 0, 0, 0, -16'sh8000, 0);
      send(ACT_BEGIN, 0, 0, 0, 0, 0, 0);
      send(ACT_POINT, 0, 31'sh50000, 1, 0, 0, 0);
      send(ACT_POINT, 31'sh3FFF_FFFF, -31'sh4000_0000, 1, 0, 0, 0);
      send(ACT_POINT, 31'sh1234, 31'sh700000, 0, 0, 0, 0);
      send(ACT_POINT, -31'sh4000_0000, 31'sh3FFF_FFFF, 0, 0, 0, 0);
      send(ACT_POINT, 31'sh4000000, 31'sh40000, 1, 1, 0, 0);
      send(ACT_POINT, 31'sh10000, 31'sh10000, 1, 1, 0, 0);
      send(ACT_POINT, 31'sh90000, 0, 1, 0, 0, 0);
      send(ACT_POINT, 31'sh100000, 31'sh10000, 0, 0, 0, 0);
      send(ACT_POINT, 31'sh200000, 31'sh20000, 0, 1, 0, 0);
      send(ACT_POINT, 0, 0, 1, 0, 0, 0);
      send(ACT_POINT, 31'sh30000, 31'sh10000, 0, 1, 0, 0);
      send(ACT_SPARE, 0, 0, 0, 0, 0, 0);
      send(ACT_END, 0, 0, 0, 0, 0, 0);
      drain();
      for (int k = 0; k < 4; k++) begin
         write_csr({1'b0, CSR_DEFAULT_WIDTH}, dw[k]);
         write_csr({1'b0, CSR_NOMINAL_WIDTH}, nw[k]);
         send(ACT_BEGIN, 0, 0, 0, 0, 16'sh7FFF, 0);
         send(ACT_BEGIN, 0, 0, 0, 0, -16'sh8000, 0);
         while (sent < 40 + (k + 1) * 90) random_glyph(1);
         if (k == 1) begin
            // long receiver hold while requests keep coming
            hold_rsp = 1;
            fork
               begin repeat (300) @(posedge clock); hold_rsp = 0; end
               begin
                  repeat (2) random_glyph(0);
                  req_valid <= 0;
                  @(posedge clock);
               end
            join
         end
         drain();
      end
      $display("covered %0d requests, %0d bytes checked, four width settings",
               sent, board.checked);
      if (board.errors == 0 && board.bytes_q.size() == 0)
         $display("tb_outline_to_type2_charstring_core: clean");
      else
         $display("tb_outline_to_type2_charstring_core: errors");
      $finish;
   end
endmodule
